FILE: design/drwc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// drwc_pkg
// Shared types, codes and constants of the grid raycaster for one screen column.
// ============================================================================
package drwc_pkg;

    // Fixed-point and datapath widths.
    localparam int FRAC_W   = 16;
    localparam int DIV_NW   = 41;   // divider numerator and quotient width
    localparam int DIV_DW   = 34;   // divider denominator width
    localparam int RAY_W    = 35;   // signed ray component width
    localparam int DELTA_W  = 41;   // cell-to-cell distance width
    localparam int ACC_W    = 52;   // side distance accumulator width
    localparam int COORD_W  = 10;   // signed map coordinate width during the walk
    localparam int CAM_W    = 31;   // signed camera coordinate width

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y       = 3'd7;

    // Register reset values.
    localparam logic [11:0]        RST_SCREEN_WIDTH  = 12'd640;
    localparam logic [11:0]        RST_SCREEN_HEIGHT = 12'd480;
    localparam logic [21:0]        RST_PLAYER_X      = 22'd65536;
    localparam logic [21:0]        RST_PLAYER_Y      = 22'd65536;
    localparam logic signed [18:0] RST_DIR_X         = 19'sd65536;
    localparam logic signed [18:0] RST_DIR_Y         = 19'sd0;
    localparam logic signed [18:0] RST_PLANE_X       = 19'sd0;
    localparam logic signed [18:0] RST_PLANE_Y       = 19'sd43254;

    // Saturation limits and special values.
    localparam logic [21:0]         DIST_MAX   = 22'h3FFFFF;
    localparam logic [16:0]         HEIGHT_MAX = 17'd100000;
    localparam logic [DELTA_W-1:0]  DELTA_INF  = 41'h100_0000_0000;
    localparam logic [DIV_NW-1:0]   RECIP_NUM  = 41'h001_0000_0000;

    // Parameter defaults.
    localparam int MAP_DIM_DEF   = 64;
    localparam int TEX_WIDTH_DEF = 64;

    // Request kinds.
    localparam logic REQ_MAP_WRITE = 1'b0;
    localparam logic REQ_CAST      = 1'b1;

    // Input and result items.
    typedef struct packed {
        logic        req_type;
        logic [5:0]  cell_x;
        logic [5:0]  cell_y;
        logic        cell_is_wall;
        logic [11:0] screen_col;
    } t_in_item;

    typedef struct packed {
        logic [11:0] column;
        logic        hit_side;
        logic [1:0]  wall_face;
        logic [21:0] perp_distance;
        logic [16:0] wall_rows;
        logic [11:0] draw_start;
        logic [11:0] draw_end;
        logic [5:0]  tex_column;
    } t_out_item;

    // Wall faces.
    localparam logic [1:0] FACE_EAST  = 2'd0;
    localparam logic [1:0] FACE_WEST  = 2'd1;
    localparam logic [1:0] FACE_SOUTH = 2'd2;
    localparam logic [1:0] FACE_NORTH = 2'd3;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_MAPWR,
        OP_LOAD,
        OP_CAM,
        OP_RAY,
        OP_DXGO,
        OP_DY,
        OP_DYSAVE,
        OP_SIDE,
        OP_STEP,
        OP_DIST,
        OP_DSAVE,
        OP_HGT,
        OP_FIN,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic div_start;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic hit;
    } t_stat;

endpackage

FILE: design/drwc_div.sv
`timescale 1ns / 1ps
// ============================================================================
// drwc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module drwc_div #(
    parameter int NW = drwc_pkg::DIV_NW,
    parameter int DW = drwc_pkg::DIV_DW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_quo,
    output logic          o_done
);

    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    r_num;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DW:0]   w_sh;
    logic [DW+1:0] w_diff;
    logic          w_geq;

    // Shift in the next numerator bit and try to subtract the divisor.
    always_comb begin
        w_sh   = {r_rem, r_num[NW-1]};
        w_diff = {1'b0, w_sh} - {2'b0, r_den};
        w_geq  = ~w_diff[DW+1];
    end

    // Control: count the quotient bits and flag the last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Data: the numerator register collects the quotient as it shifts out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], w_geq};
            r_rem <= w_geq ? w_diff[DW-1:0] : w_sh[DW-1:0];
        end
    end

    assign o_quo  = r_num;
    assign o_done = r_done;

endmodule

FILE: design/drwc_dpath.sv
`timescale 1ns / 1ps
// ============================================================================
// drwc_dpath
// Raycaster datapath: pose registers, map store, ray setup, grid walk,
// distance, height, span and texture column.
// ============================================================================
module drwc_dpath #(
    parameter int MAP_DIM   = drwc_pkg::MAP_DIM_DEF,
    parameter int TEX_WIDTH = drwc_pkg::TEX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [drwc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [drwc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  drwc_pkg::t_in_item              i_in_item,
    input  drwc_pkg::t_cmd                  i_cmd,
    output drwc_pkg::t_stat                 o_stat,
    output drwc_pkg::t_out_item             o_out_item
);

    localparam int AW    = $clog2(MAP_DIM);
    localparam int DEPTH = 1 << (2 * AW);
    localparam int TW_W  = $clog2(TEX_WIDTH + 1);
    localparam int TP_W  = drwc_pkg::FRAC_W + TW_W;
    localparam int CW    = drwc_pkg::COORD_W;
    localparam int RW    = drwc_pkg::RAY_W;

    // Configuration registers.
    logic [11:0]        r_sw, r_sh;
    logic [21:0]        r_px, r_py;
    logic signed [18:0] r_dirx, r_diry, r_plx, r_ply;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw   <= drwc_pkg::RST_SCREEN_WIDTH;
            r_sh   <= drwc_pkg::RST_SCREEN_HEIGHT;
            r_px   <= drwc_pkg::RST_PLAYER_X;
            r_py   <= drwc_pkg::RST_PLAYER_Y;
            r_dirx <= drwc_pkg::RST_DIR_X;
            r_diry <= drwc_pkg::RST_DIR_Y;
            r_plx  <= drwc_pkg::RST_PLANE_X;
            r_ply  <= drwc_pkg::RST_PLANE_Y;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                drwc_pkg::CFG_SCREEN_WIDTH:  r_sw   <= i_cfg_data[11:0];
                drwc_pkg::CFG_SCREEN_HEIGHT: r_sh   <= i_cfg_data[11:0];
                drwc_pkg::CFG_PLAYER_X:      r_px   <= i_cfg_data;
                drwc_pkg::CFG_PLAYER_Y:      r_py   <= i_cfg_data;
                drwc_pkg::CFG_DIR_X:         r_dirx <= signed'(i_cfg_data[18:0]);
                drwc_pkg::CFG_DIR_Y:         r_diry <= signed'(i_cfg_data[18:0]);
                drwc_pkg::CFG_PLANE_X:       r_plx  <= signed'(i_cfg_data[18:0]);
                drwc_pkg::CFG_PLANE_Y:       r_ply  <= signed'(i_cfg_data[18:0]);
                default: ;
            endcase
        end
    end

    // Working registers of one cast.
    logic [11:0]             r_col;
    logic signed [drwc_pkg::CAM_W-1:0] r_cam;
    logic signed [RW-1:0]    r_rx, r_ry;
    logic [drwc_pkg::DELTA_W-1:0] r_dx, r_dy;
    logic [drwc_pkg::ACC_W-1:0]   r_sx, r_sy;
    logic [CW-1:0]           r_mx, r_my;
    logic                    r_side;
    logic                    r_rdata;
    logic [21:0]             r_dist;
    logic [16:0]             r_height;
    logic [31:0]             r_wlow;
    logic [15:0]             r_frac;
    drwc_pkg::t_out_item     r_out;
    logic                    r_map [0:DEPTH-1];

    // Effective screen size: zero counts as one.
    logic [11:0] w_w, w_h;
    assign w_w = (r_sw == 12'd0) ? 12'd1 : r_sw;
    assign w_h = (r_sh == 12'd0) ? 12'd1 : r_sh;

    // Ray magnitudes and signs.
    logic [drwc_pkg::DIV_DW-1:0] w_rxa, w_rya;
    logic w_rx0, w_ry0, w_rxneg, w_ryneg, w_rypos, w_rxpos;
    always_comb begin
        w_rxneg = r_rx[RW-1];
        w_ryneg = r_ry[RW-1];
        w_rx0   = (r_rx == '0);
        w_ry0   = (r_ry == '0);
        w_rxpos = !w_rxneg && !w_rx0;
        w_rypos = !w_ryneg && !w_ry0;
        w_rxa   = w_rxneg ? drwc_pkg::DIV_DW'(-r_rx) : r_rx[drwc_pkg::DIV_DW-1:0];
        w_rya   = w_ryneg ? drwc_pkg::DIV_DW'(-r_ry) : r_ry[drwc_pkg::DIV_DW-1:0];
    end

    // Ray components from the camera coordinate.
    logic signed [49:0] w_pmx, w_pmy;
    assign w_pmx = 50'(r_plx) * 50'(r_cam);
    assign w_pmy = 50'(r_ply) * 50'(r_cam);

    // Distance from the player to the first grid line on each axis.
    logic [16:0] w_fx, w_fy;
    logic [49:0] w_psx, w_psy;
    always_comb begin
        w_fx  = w_rxneg ? {1'b0, r_px[15:0]} : 17'h10000 - {1'b0, r_px[15:0]};
        w_fy  = w_ryneg ? {1'b0, r_py[15:0]} : 17'h10000 - {1'b0, r_py[15:0]};
        w_psx = 50'(w_fx) * 50'(r_dx[32:0]);
        w_psy = 50'(w_fy) * 50'(r_dy[32:0]);
    end

    // One DDA step: the axis with the smaller side distance advances, x on a tie.
    logic          w_ystep;
    logic [CW-1:0] n_mx, n_my;
    always_comb begin
        w_ystep = (r_sx > r_sy);
        n_mx = r_mx;
        n_my = r_my;
        if (w_ystep) begin
            n_my = r_my + (w_ryneg ? {CW{1'b1}} : CW'(1));
        end else begin
            n_mx = r_mx + (w_rxneg ? {CW{1'b1}} : CW'(1));
        end
    end

    // Wall test of the current cell: outside the map or a stored wall.
    logic w_oob;
    assign w_oob = r_mx[CW-1] || r_my[CW-1] ||
                   (r_mx >= CW'(MAP_DIM)) || (r_my >= CW'(MAP_DIM));
    assign o_stat.hit = w_oob || r_rdata;

    // Distance numerator on the axis that was hit.
    logic [CW-1:0]      w_hc;
    logic [21:0]        w_hp;
    logic               w_hneg;
    logic signed [26:0] w_numv;
    logic [24:0]        w_numa;
    always_comb begin
        w_hc   = r_side ? r_my : r_mx;
        w_hp   = r_side ? r_py : r_px;
        w_hneg = r_side ? w_ryneg : w_rxneg;
        w_numv = signed'({w_hc[CW-1], w_hc, 16'h0000}) - signed'(27'(w_hp))
                 + (w_hneg ? 27'sd65536 : 27'sd0);
        w_numa = w_numv[26] ? 25'(-w_numv) : w_numv[24:0];
    end

    // Shared divider with its operand selection.
    logic [drwc_pkg::DIV_NW-1:0] w_dnum, w_quo;
    logic [drwc_pkg::DIV_DW-1:0] w_dden;
    logic                        w_ddone;
    always_comb begin
        w_dnum = '0;
        w_dden = '0;
        case (i_cmd.op)
            drwc_pkg::OP_LOAD: begin
                w_dnum = drwc_pkg::DIV_NW'({i_in_item.screen_col, 17'h00000});
                w_dden = drwc_pkg::DIV_DW'(w_w);
            end
            drwc_pkg::OP_DXGO: begin
                w_dnum = drwc_pkg::RECIP_NUM;
                w_dden = w_rxa;
            end
            drwc_pkg::OP_DY: begin
                w_dnum = drwc_pkg::RECIP_NUM;
                w_dden = w_rya;
            end
            drwc_pkg::OP_DIST: begin
                w_dnum = {w_numa, 16'h0000};
                w_dden = r_side ? w_rya : w_rxa;
            end
            drwc_pkg::OP_HGT: begin
                w_dnum = drwc_pkg::DIV_NW'({w_h, 16'h0000});
                w_dden = drwc_pkg::DIV_DW'(r_dist);
            end
            default: ;
        endcase
    end

    drwc_div #(
        .NW(drwc_pkg::DIV_NW),
        .DW(drwc_pkg::DIV_DW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (w_dnum),
        .i_den  (w_dden),
        .o_quo  (w_quo),
        .o_done (w_ddone)
    );
    assign o_stat.div_done = w_ddone;

    // Texture hit coordinate term and draw span.
    logic [RW-1:0]  w_tsel;
    logic [31:0]    w_wlow;
    logic [15:0]    w_hh;
    logic [10:0]    w_hs;
    logic [17:0]    w_st;
    logic [16:0]    w_end;
    logic [TP_W-1:0] w_tprod;
    logic [TW_W-1:0] w_tex, w_texm;
    logic            w_mirror;
    logic [1:0]      w_face;
    always_comb begin
        w_tsel   = r_side ? r_rx : r_ry;
        w_wlow   = 32'(r_dist) * w_tsel[31:0];
        w_hh     = r_height[16:1];
        w_hs     = w_h[11:1];
        w_st     = {7'b0, w_hs} - {2'b0, w_hh};
        w_end    = 17'(w_hs) + 17'(w_hh);
        w_tprod  = TP_W'(r_frac) * TP_W'(TEX_WIDTH);
        w_tex    = w_tprod[TP_W-1:drwc_pkg::FRAC_W];
        w_mirror = (!r_side && w_rxpos) || (r_side && w_ryneg);
        w_texm   = w_mirror ? (TW_W'(TEX_WIDTH - 1) - w_tex) : w_tex;
        if (r_side && w_rypos) begin
            w_face = drwc_pkg::FACE_EAST;
        end else if (r_side && w_ryneg) begin
            w_face = drwc_pkg::FACE_WEST;
        end else if (!r_side && w_rxpos) begin
            w_face = drwc_pkg::FACE_SOUTH;
        end else begin
            w_face = drwc_pkg::FACE_NORTH;
        end
    end

    // Map write address and range check.
    logic [8:0] w_cx, w_cy;
    logic       w_win;
    assign w_cx  = 9'(i_in_item.cell_x);
    assign w_cy  = 9'(i_in_item.cell_y);
    assign w_win = (w_cx < 9'(MAP_DIM)) && (w_cy < 9'(MAP_DIM));

    // Map store: written by map-write transfers, read once per walk step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == drwc_pkg::OP_MAPWR && w_win) begin
            r_map[{w_cx[AW-1:0], w_cy[AW-1:0]}] <= i_in_item.cell_is_wall;
        end
        if (i_cmd.op == drwc_pkg::OP_STEP) begin
            r_rdata <= r_map[{n_mx[AW-1:0], n_my[AW-1:0]}];
        end
    end

    // Cast working registers, advanced by the controller's operations.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            drwc_pkg::OP_LOAD: begin
                r_col <= i_in_item.screen_col;
            end
            drwc_pkg::OP_CAM: begin
                r_cam <= signed'(w_quo[drwc_pkg::CAM_W-1:0]) - 31'sd65536;
            end
            drwc_pkg::OP_RAY: begin
                r_rx <= RW'(r_dirx) + RW'(w_pmx >>> 16);
                r_ry <= RW'(r_diry) + RW'(w_pmy >>> 16);
            end
            drwc_pkg::OP_DY: begin
                r_dx <= w_rx0 ? drwc_pkg::DELTA_INF : w_quo;
            end
            drwc_pkg::OP_DYSAVE: begin
                r_dy <= w_ry0 ? drwc_pkg::DELTA_INF : w_quo;
            end
            drwc_pkg::OP_SIDE: begin
                r_sx <= w_rx0 ? drwc_pkg::ACC_W'({w_fx, 24'h000000})
                              : drwc_pkg::ACC_W'(w_psx[49:16]);
                r_sy <= w_ry0 ? drwc_pkg::ACC_W'({w_fy, 24'h000000})
                              : drwc_pkg::ACC_W'(w_psy[49:16]);
                r_mx <= CW'(r_px[21:16]);
                r_my <= CW'(r_py[21:16]);
            end
            drwc_pkg::OP_STEP: begin
                r_side <= w_ystep;
                r_mx   <= n_mx;
                r_my   <= n_my;
                if (w_ystep) begin
                    r_sy <= r_sy + drwc_pkg::ACC_W'(r_dy);
                end else begin
                    r_sx <= r_sx + drwc_pkg::ACC_W'(r_dx);
                end
            end
            drwc_pkg::OP_DSAVE: begin
                if ((r_side ? w_ry0 : w_rx0) || (w_quo[drwc_pkg::DIV_NW-1:22] != '0)) begin
                    r_dist <= drwc_pkg::DIST_MAX;
                end else begin
                    r_dist <= w_quo[21:0];
                end
            end
            drwc_pkg::OP_HGT: begin
                r_wlow <= w_wlow;
            end
            drwc_pkg::OP_FIN: begin
                if (r_dist == '0 || w_quo > drwc_pkg::DIV_NW'(drwc_pkg::HEIGHT_MAX)) begin
                    r_height <= drwc_pkg::HEIGHT_MAX;
                end else begin
                    r_height <= w_quo[16:0];
                end
                r_frac <= (r_side ? r_px[15:0] : r_py[15:0]) + r_wlow[31:16];
            end
            drwc_pkg::OP_OUT: begin
                r_out.column        <= r_col;
                r_out.hit_side      <= r_side;
                r_out.wall_face     <= w_face;
                r_out.perp_distance <= r_dist;
                r_out.wall_rows     <= r_height;
                r_out.draw_start    <= w_st[17] ? 12'd1 : w_st[11:0];
                r_out.draw_end      <= (w_end >= 17'(w_h)) ? (w_h - 12'd1) : w_end[11:0];
                r_out.tex_column    <= 6'(w_texm);
            end
            default: ;
        endcase
    end

    assign o_out_item = r_out;

endmodule

FILE: design/drwc_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// drwc_ctrl
// Raycaster controller: issues map writes and sequences ray setup, divisions,
// grid walk and the result transfer.
// ============================================================================
module drwc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_req_type,
    input  logic            i_out_stall,
    input  drwc_pkg::t_stat i_stat,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output drwc_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CAMW,
        S_RAY,
        S_DX,
        S_DXW,
        S_DYW,
        S_SIDE,
        S_WALK,
        S_TEST,
        S_DISTW,
        S_HGT,
        S_HGTW,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid;
    logic   w_out_busy;

    assign w_out_busy = r_ovalid && i_out_stall;

    // Next state and the operation for the datapath.
    always_comb begin
        n_state     = r_state;
        o_cmd.op    = drwc_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_req_type == drwc_pkg::REQ_CAST) begin
                        o_cmd.op = drwc_pkg::OP_LOAD;
                        n_state  = S_CAMW;
                    end else begin
                        o_cmd.op = drwc_pkg::OP_MAPWR;
                    end
                end
            end
            S_CAMW: begin
                if (i_stat.div_done) begin
                    o_cmd.op = drwc_pkg::OP_CAM;
                    n_state  = S_RAY;
                end
            end
            S_RAY: begin
                o_cmd.op = drwc_pkg::OP_RAY;
                n_state  = S_DX;
            end
            S_DX: begin
                o_cmd.op = drwc_pkg::OP_DXGO;
                n_state  = S_DXW;
            end
            S_DXW: begin
                if (i_stat.div_done) begin
                    o_cmd.op = drwc_pkg::OP_DY;
                    n_state  = S_DYW;
                end
            end
            S_DYW: begin
                if (i_stat.div_done) begin
                    o_cmd.op = drwc_pkg::OP_DYSAVE;
                    n_state  = S_SIDE;
                end
            end
            S_SIDE: begin
                o_cmd.op = drwc_pkg::OP_SIDE;
                n_state  = S_WALK;
            end
            S_WALK: begin
                o_cmd.op = drwc_pkg::OP_STEP;
                n_state  = S_TEST;
            end
            S_TEST: begin
                if (i_stat.hit) begin
                    o_cmd.op = drwc_pkg::OP_DIST;
                    n_state  = S_DISTW;
                end else begin
                    o_cmd.op = drwc_pkg::OP_STEP;
                end
            end
            S_DISTW: begin
                if (i_stat.div_done) begin
                    o_cmd.op = drwc_pkg::OP_DSAVE;
                    n_state  = S_HGT;
                end
            end
            S_HGT: begin
                o_cmd.op = drwc_pkg::OP_HGT;
                n_state  = S_HGTW;
            end
            S_HGTW: begin
                if (i_stat.div_done) begin
                    o_cmd.op = drwc_pkg::OP_FIN;
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                if (!w_out_busy) begin
                    o_cmd.op = drwc_pkg::OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_cmd.div_start = (o_cmd.op == drwc_pkg::OP_LOAD) || (o_cmd.op == drwc_pkg::OP_DXGO) ||
                          (o_cmd.op == drwc_pkg::OP_DY)   || (o_cmd.op == drwc_pkg::OP_DIST) ||
                          (o_cmd.op == drwc_pkg::OP_HGT);
    end

    // State and the result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.op == drwc_pkg::OP_OUT) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;

`ifndef SYNTH
    // A division finishes only while the controller waits for it.
    a_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state == S_CAMW || r_state == S_DXW || r_state == S_DYW ||
                             r_state == S_DISTW || r_state == S_HGTW))
        else $error("divider finished outside a wait state");

    // An accepted cast starts the camera division.
    a_cast_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_req_type == drwc_pkg::REQ_CAST) |=>
        (r_state == S_CAMW))
        else $error("cast transfer did not start the ray setup");

    // A finished result is presented once the output register is free.
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !w_out_busy) |=> (r_ovalid && r_state == S_IDLE))
        else $error("finished result was not presented");

    // A map write never leaves the idle state.
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_req_type == drwc_pkg::REQ_MAP_WRITE) |=>
        (r_state == S_IDLE))
        else $error("map write left the idle state");
`endif

endmodule

FILE: design/dda_ray_wall_column.sv
`timescale 1ns / 1ps
// ============================================================================
// dda_ray_wall_column
// Grid raycaster for one screen column: map writes and DDA column casts.
// ============================================================================
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_stall | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_item (t_out_item)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  A map write gives no result and leaves the controller idle.
//  A cast runs five divisions in the shared one-bit-per-cycle divider
//  (camera coordinate, two step lengths, distance, height) and walks the grid
//  one cell per step (up to about two map dimensions).
//  The result register frees the input side: the next item is taken while a
//  result waits under stall. Reset is synchronous; the map store is not cleared.
//
module dda_ray_wall_column #(
    parameter int MAP_DIM   = drwc_pkg::MAP_DIM_DEF,
    parameter int TEX_WIDTH = drwc_pkg::TEX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  drwc_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output drwc_pkg::t_out_item             o_out_item,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [drwc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [drwc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    drwc_pkg::t_cmd  w_cmd;
    drwc_pkg::t_stat w_stat;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    // Sequencer.
    drwc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_item.req_type),
        .i_out_stall(i_out_stall),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_cmd      (w_cmd)
    );

    // Arithmetic, map store and result register.
    drwc_dpath #(
        .MAP_DIM  (MAP_DIM),
        .TEX_WIDTH(TEX_WIDTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_item  (i_in_item),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out_item (o_out_item)
    );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// Raycaster column testbench
// Fills the map with walls, then casts columns under many player poses and
// screen sizes. Every cast result is checked against a bit-exact predictor.
// Both channels see random idle bursts.
// ============================================================================

// Scoreboard: holds the predicted column results and the predictor state.
class column_scoreboard;
    bit          wall_map[64][64];
    logic [11:0] scr_w, scr_h;
    logic [21:0] pos_x, pos_y;
    longint      vdir_x, vdir_y, vplane_x, vplane_y;
    drwc_pkg::t_out_item pending[$];
    int          mismatches;
    int          casts_checked;

    function void reset_regs();
        scr_w = 640; scr_h = 480; pos_x = 65536; pos_y = 65536;
        vdir_x = 65536; vdir_y = 0; vplane_x = 0; vplane_y = 43254;
    endfunction

    function void write_reg(logic [drwc_pkg::CFG_IDX_W-1:0] idx,
                            logic [drwc_pkg::CFG_DATA_W-1:0] d);
        logic signed [18:0] s;
        s = d[18:0];
        case (idx)
            drwc_pkg::CFG_SCREEN_WIDTH:  scr_w = d[11:0];
            drwc_pkg::CFG_SCREEN_HEIGHT: scr_h = d[11:0];
            drwc_pkg::CFG_PLAYER_X:      pos_x = d;
            drwc_pkg::CFG_PLAYER_Y:      pos_y = d;
            drwc_pkg::CFG_DIR_X:         vdir_x = s;
            drwc_pkg::CFG_DIR_Y:         vdir_y = s;
            drwc_pkg::CFG_PLANE_X:       vplane_x = s;
            drwc_pkg::CFG_PLANE_Y:       vplane_y = s;
            default: ;
        endcase
    endfunction

    // Arithmetic shift rounds toward minus infinity, as the block does.
    function longint fshr(longint v);
        return v >>> 16;
    endfunction

    function longint absv(longint v);
        return v < 0 ? -v : v;
    endfunction

    function bit blocked(longint cx, longint cy);
        if (cx < 0 || cy < 0 || cx >= 64 || cy >= 64) return 1;
        return wall_map[cx][cy];
    endfunction

    // Predicts the result of an accepted transfer; map writes update the map.
    function void note_input(drwc_pkg::t_in_item it);
        longint w, h, cam, rx, ry, mx, my, dx, dy, sx, sy, stx, sty;
        longint num, rd, pdist, hgt, hs, st, en, wx, tex;
        int side;
        drwc_pkg::t_out_item r;
        if (it.req_type == drwc_pkg::REQ_MAP_WRITE) begin
            wall_map[it.cell_x][it.cell_y] = it.cell_is_wall;
            return;
        end
        w = scr_w ? scr_w : 1;
        h = scr_h ? scr_h : 1;
        cam = (2 * longint'(it.screen_col) * 65536) / w - 65536;
        rx = vdir_x + fshr(vplane_x * cam);
        ry = vdir_y + fshr(vplane_y * cam);
        mx = pos_x >> 16;
        my = pos_y >> 16;
        dx = rx != 0 ? (64'd1 << 32) / absv(rx) : (64'd1 << 40);
        dy = ry != 0 ? (64'd1 << 32) / absv(ry) : (64'd1 << 40);
        if (rx < 0) begin
            stx = -1; sx = ((pos_x - (mx << 16)) * dx) >> 16;
        end else begin
            stx = 1; sx = ((((mx + 1) << 16) - pos_x) * dx) >> 16;
        end
        if (ry < 0) begin
            sty = -1; sy = ((pos_y - (my << 16)) * dy) >> 16;
        end else begin
            sty = 1; sy = ((((my + 1) << 16) - pos_y) * dy) >> 16;
        end
        do begin
            if (sx > sy) begin
                side = 1; sy += dy; my += sty;
            end else begin
                side = 0; sx += dx; mx += stx;
            end
        end while (!blocked(mx, my));
        if (side == 0) begin
            num = absv(mx * 65536 - pos_x + (stx < 0 ? 65536 : 0)); rd = rx;
        end else begin
            num = absv(my * 65536 - pos_y + (sty < 0 ? 65536 : 0)); rd = ry;
        end
        if (rd == 0) pdist = drwc_pkg::DIST_MAX;
        else begin
            pdist = (num << 16) / absv(rd);
            if (pdist > drwc_pkg::DIST_MAX) pdist = drwc_pkg::DIST_MAX;
        end
        if (pdist == 0) hgt = drwc_pkg::HEIGHT_MAX;
        else begin
            hgt = (h << 16) / pdist;
            if (hgt > drwc_pkg::HEIGHT_MAX) hgt = drwc_pkg::HEIGHT_MAX;
        end
        hs = h / 2;
        st = hs - hgt / 2;
        en = hs + hgt / 2;
        if (st < 0) st = 1;
        if (en >= h) en = h - 1;
        // A side-one hit with a flat ray falls through to the north face.
        if (side == 1 && ry > 0) r.wall_face = drwc_pkg::FACE_EAST;
        else if (side == 1 && ry < 0) r.wall_face = drwc_pkg::FACE_WEST;
        else if (side == 0 && rx > 0) r.wall_face = drwc_pkg::FACE_SOUTH;
        else r.wall_face = drwc_pkg::FACE_NORTH;
        if (side == 0) wx = pos_y + fshr(pdist * ry);
        else wx = pos_x + fshr(pdist * rx);
        tex = ((wx & 16'hFFFF) * 64) >> 16;
        if ((side == 0 && rx > 0) || (side == 1 && ry < 0)) tex = 63 - tex;
        r.column = it.screen_col;
        r.hit_side = side[0];
        r.perp_distance = pdist[21:0];
        r.wall_rows = hgt[16:0];
        r.draw_start = st[11:0];
        r.draw_end = en[11:0];
        r.tex_column = tex[5:0];
        pending.push_back(r);
    endfunction

    function void check_result(drwc_pkg::t_out_item got);
        drwc_pkg::t_out_item exp_r;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result: %p", got);
            return;
        end
        exp_r = pending.pop_front();
        casts_checked++;
        if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Result mismatch:\n  expected %p\n  actual   %p", exp_r, got);
        end
    endfunction
endclass

module tb_top;
    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      i_in_valid = 0;
    logic      o_in_stall;
    drwc_pkg::t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 0;
    drwc_pkg::t_out_item o_out_item;
    logic      i_cfg_valid = 0;
    logic      o_cfg_ready;
    logic [drwc_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [drwc_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    column_scoreboard sb;
    longint cycles = 0;
    bit     calm = 0;
    int     items_sent = 0;

    dda_ray_wall_column u_dut (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    // Watchdog: fails the run if it does not finish in time.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 12000000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Output side: check every transfer, stall in random bursts.
    initial begin
        int burst;
        burst = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_item);
            @(negedge i_clk);
            if (burst > 0) burst--;
            else if (!calm && $urandom_range(0, 9) == 0) burst = $urandom_range(1, 7);
            i_out_stall <= (burst > 0);
        end
    end

    // Valid stays up between back-to-back items; idling or a drain drops it.
    task automatic send_item(drwc_pkg::t_in_item it);
        i_cfg_valid <= 0;
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_cell(int x, int y, bit wall);
        drwc_pkg::t_in_item it;
        it = '0;
        it.req_type = drwc_pkg::REQ_MAP_WRITE;
        it.cell_x = 6'(x); it.cell_y = 6'(y); it.cell_is_wall = wall;
        it.screen_col = 12'($urandom);
        send_item(it);
    endtask

    task automatic cast_column(logic [11:0] c);
        drwc_pkg::t_in_item it;
        it = 26'($urandom);
        it.req_type = drwc_pkg::REQ_CAST;
        it.screen_col = c;
        send_item(it);
    endtask

    // Waits until every prediction is met, plus the latency of a write.
    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Valid stays up between back-to-back writes; the next item drops it.
    task automatic write_reg(logic [drwc_pkg::CFG_IDX_W-1:0] idx,
                             logic [drwc_pkg::CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, d);
        @(negedge i_clk);
    endtask

    function automatic logic [21:0] rand_vec();
        int v;
        v = $urandom_range(0, 262144) - 131072;
        if ($urandom_range(0, 7) == 0) v = 0;
        return 22'(v);
    endfunction

    // Random pose and screen size: player mostly inside the map, sometimes anywhere.
    task automatic random_pose();
        logic [11:0] w;
        w = $urandom_range(0, 5) == 0 ? 12'($urandom_range(0, 4095)) :
            12'($urandom_range(1, 700));
        write_reg(drwc_pkg::CFG_SCREEN_WIDTH, 22'(w));
        write_reg(drwc_pkg::CFG_SCREEN_HEIGHT, 22'($urandom_range(0, 5) == 0 ?
                  $urandom_range(0, 4095) : $urandom_range(1, 600)));
        write_reg(drwc_pkg::CFG_PLAYER_X, 22'($urandom_range(0, 9) == 0 ?
                  $urandom_range(0, 4194303) : $urandom_range(65536, 62 * 65536)));
        write_reg(drwc_pkg::CFG_PLAYER_Y, 22'($urandom_range(0, 9) == 0 ?
                  $urandom_range(0, 4194303) : $urandom_range(65536, 62 * 65536)));
        write_reg(drwc_pkg::CFG_DIR_X, rand_vec());
        write_reg(drwc_pkg::CFG_DIR_Y, rand_vec());
        write_reg(drwc_pkg::CFG_PLANE_X, rand_vec());
        write_reg(drwc_pkg::CFG_PLANE_Y, rand_vec());
    endtask

    initial begin
        int phase;
        logic [11:0] col;
        sb = new();
        sb.reset_regs();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Fill the map: a sparse random maze with the first two rows and columns empty.
        for (int x = 0; x < 64; x++)
            for (int y = 0; y < 64; y++)
                write_cell(x, y, (x > 1 && y > 1 && $urandom_range(0, 5) == 0));

        // Directed: reset pose, edge columns, extreme sizes and poses.
        cast_column(12'd0); cast_column(12'd639); cast_column(12'd320);
        cast_column(12'd4095);
        drain();
        write_reg(drwc_pkg::CFG_SCREEN_WIDTH, 22'd0);
        write_reg(drwc_pkg::CFG_SCREEN_HEIGHT, 22'd0);
        cast_column(12'd0); cast_column(12'd1);
        drain();
        write_reg(drwc_pkg::CFG_SCREEN_WIDTH, 22'd4095);
        write_reg(drwc_pkg::CFG_SCREEN_HEIGHT, 22'd4095);
        write_reg(drwc_pkg::CFG_PLAYER_X, 22'h3FFFFF);
        write_reg(drwc_pkg::CFG_PLAYER_Y, 22'd0);
        write_reg(drwc_pkg::CFG_DIR_X, 22'(-131072));
        write_reg(drwc_pkg::CFG_DIR_Y, 22'd131072);
        write_reg(drwc_pkg::CFG_PLANE_X, 22'd0);
        write_reg(drwc_pkg::CFG_PLANE_Y, 22'd0);
        cast_column(12'd0); cast_column(12'd4095);
        drain();
        // Axis-aligned rays, player on a cell corner, tiny distance.
        write_reg(drwc_pkg::CFG_PLAYER_X, 22'd65536);
        write_reg(drwc_pkg::CFG_PLAYER_Y, 22'd65536);
        write_reg(drwc_pkg::CFG_DIR_X, 22'd0);
        write_reg(drwc_pkg::CFG_DIR_Y, 22'(-131072));
        write_reg(drwc_pkg::CFG_SCREEN_WIDTH, 22'd2);
        cast_column(12'd1); cast_column(12'd0);
        drain();
        write_reg(drwc_pkg::CFG_DIR_X, 22'd65536);
        write_reg(drwc_pkg::CFG_DIR_Y, 22'd65536);
        cast_column(12'd1);
        write_cell(1, 2, 1); write_cell(2, 1, 1); write_cell(63, 63, 1);
        cast_column(12'd1);
        drain();

        // Random phases: a pose, then casts mixed with map writes.
        phase = 0;
        while (items_sent < 1900 + 4100) begin
            random_pose();
            if (items_sent > 5700) calm = 1;
            repeat ($urandom_range(10, 40)) begin
                if ($urandom_range(0, 3) == 0)
                    write_cell($urandom_range(0, 63), $urandom_range(0, 63),
                               $urandom_range(0, 5) == 0);
                else begin
                    col = $urandom_range(0, 3) == 0 ? 12'($urandom) :
                          12'($urandom_range(0, sb.scr_w ? sb.scr_w - 1 : 0));
                    cast_column(col);
                end
            end
            // Hold the sender until every outstanding column is back.
            drain();
            phase++;
        end

        calm = 1;
        drain();
        repeat (50) @(negedge i_clk);
        $display("Checked %0d cast results over %0d pose phases; %0d mismatches.",
                 sb.casts_checked, phase, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
